// File: design/sha1md_pkg.sv
// shared types, constants and helpers for the sha-1 digest core
package sha1md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWin  = 16;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned NumHash = 5;
  localparam int unsigned OutW    = 40;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [6:0] RndLast = 7'd79;
  localparam logic [2:0] IdxLast = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PUSH_DATA,
    PUSH_MARK,
    PUSH_ZERO,
    PUSH_LEN
  } push_sel_t;

  typedef struct packed {
    logic      push;
    push_sel_t push_sel;
    logic      len_inc;
    logic      load_rounds;
    logic      round_step;
    logic      fold;
    logic      reinit;
    logic [2:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic cnt_is_63;
    logic cnt_is_56;
    logic round_last;
  } stat_t;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

endpackage

// File: design/sha1md_datapath.sv
// block window, length counter, round unit and chaining value
module sha1md_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1md_pkg::cmd_t     cmd,
  input  logic [7:0]           data_byte,
  output sha1md_pkg::stat_t    stat,
  output logic [31:0]          digest_word
);

  logic [31:0] win_r   [sha1md_pkg::NumWin];
  logic [31:0] chain_r [sha1md_pkg::NumHash];
  logic [31:0] rnd_r   [sha1md_pkg::NumHash];
  logic [5:0]  cnt_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_cnt_r;

  logic [7:0]  push_byte;
  logic [63:0] len_sh;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] tmp;

  // length bytes go out most significant first while the count runs 56..63
  assign len_sh = len_r >> {~cnt_r[2:0], 3'b000};

  always_comb begin
    case (cmd.push_sel)
      sha1md_pkg::PUSH_DATA: push_byte = data_byte;
      sha1md_pkg::PUSH_MARK: push_byte = sha1md_pkg::PadMark;
      sha1md_pkg::PUSH_ZERO: push_byte = 8'h00;
      sha1md_pkg::PUSH_LEN:  push_byte = len_sh[7:0];
      default:               push_byte = 8'h00;
    endcase
  end

  assign w_new = sha1md_pkg::rotl1(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0]);

  always_comb begin
    if (rnd_cnt_r < 7'd20) begin
      f_val = (rnd_r[1] & rnd_r[2]) | (~rnd_r[1] & rnd_r[3]);
      k_val = sha1md_pkg::K0;
    end else if (rnd_cnt_r < 7'd40) begin
      f_val = rnd_r[1] ^ rnd_r[2] ^ rnd_r[3];
      k_val = sha1md_pkg::K1;
    end else if (rnd_cnt_r < 7'd60) begin
      f_val = (rnd_r[1] & rnd_r[2]) | (rnd_r[1] & rnd_r[3]) | (rnd_r[2] & rnd_r[3]);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = rnd_r[1] ^ rnd_r[2] ^ rnd_r[3];
      k_val = sha1md_pkg::K3;
    end
  end

  assign tmp = sha1md_pkg::rotl5(rnd_r[0]) + f_val + rnd_r[4] + win_r[0] + k_val;

  // window doubles as block buffer: bytes shift in, then words shift out per round
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < sha1md_pkg::NumWin - 1; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[sha1md_pkg::NumWin-1] <= {win_r[sha1md_pkg::NumWin-1][23:0], push_byte};
    end else if (cmd.round_step) begin
      for (int i = 0; i < sha1md_pkg::NumWin - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha1md_pkg::NumWin-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rounds) begin
      for (int i = 0; i < sha1md_pkg::NumHash; i++) begin
        rnd_r[i] <= chain_r[i];
      end
    end else if (cmd.round_step) begin
      rnd_r[4] <= rnd_r[3];
      rnd_r[3] <= rnd_r[2];
      rnd_r[2] <= sha1md_pkg::rotl30(rnd_r[1]);
      rnd_r[1] <= rnd_r[0];
      rnd_r[0] <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_cnt_r <= '0;
    end else if (cmd.load_rounds) begin
      rnd_cnt_r <= '0;
    end else if (cmd.round_step) begin
      rnd_cnt_r <= rnd_cnt_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      chain_r[0] <= sha1md_pkg::IV0;
      chain_r[1] <= sha1md_pkg::IV1;
      chain_r[2] <= sha1md_pkg::IV2;
      chain_r[3] <= sha1md_pkg::IV3;
      chain_r[4] <= sha1md_pkg::IV4;
    end else if (cmd.fold) begin
      for (int i = 0; i < sha1md_pkg::NumHash; i++) begin
        chain_r[i] <= chain_r[i] + rnd_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.push) begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (cmd.len_inc) begin
        len_r <= len_r + 64'd8;
      end
    end
  end

  assign stat.cnt_is_63  = (cnt_r == 6'd63);
  assign stat.cnt_is_56  = (cnt_r == 6'd56);
  assign stat.round_last = (rnd_cnt_r == sha1md_pkg::RndLast);

  always_comb begin
    case (cmd.emit_idx)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

endmodule

// File: design/sha1md_ctrl.sv
// sequencer for byte intake, padding, compression rounds and digest output
module sha1md_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_kind,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output sha1md_pkg::cmd_t     cmd,
  input  sha1md_pkg::stat_t    stat
);

  sha1md_pkg::state_t state_r, state_nxt;
  logic       pad_mode_r, pad_mode_nxt;
  logic       len_phase_r, len_phase_nxt;
  logic       done_r, done_nxt;
  logic [2:0] emit_idx_r, emit_idx_nxt;
  logic       in_acc;
  logic       len_now;

  assign in_acc  = in_tvalid && (state_r == sha1md_pkg::ST_IDLE);
  assign len_now = len_phase_r || stat.cnt_is_56;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1md_pkg::ST_IDLE;
      pad_mode_r  <= 1'b0;
      len_phase_r <= 1'b0;
      done_r      <= 1'b0;
      emit_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      pad_mode_r  <= pad_mode_nxt;
      len_phase_r <= len_phase_nxt;
      done_r      <= done_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pad_mode_nxt  = pad_mode_r;
    len_phase_nxt = len_phase_r;
    done_nxt      = done_r;
    emit_idx_nxt  = emit_idx_r;
    case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind) begin
            pad_mode_nxt = 1'b1;
            state_nxt    = stat.cnt_is_63 ? sha1md_pkg::ST_ROUND : sha1md_pkg::ST_PAD;
          end else if (stat.cnt_is_63) begin
            state_nxt = sha1md_pkg::ST_ROUND;
          end
        end
      end
      sha1md_pkg::ST_ROUND: begin
        if (stat.round_last) begin
          state_nxt = sha1md_pkg::ST_FOLD;
        end
      end
      sha1md_pkg::ST_FOLD: begin
        if (done_r) begin
          state_nxt = sha1md_pkg::ST_EMIT;
        end else if (pad_mode_r) begin
          state_nxt = sha1md_pkg::ST_PAD;
        end else begin
          state_nxt = sha1md_pkg::ST_IDLE;
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (len_now) begin
          len_phase_nxt = 1'b1;
        end
        if (stat.cnt_is_63) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          if (len_now) begin
            done_nxt = 1'b1;
          end
        end
      end
      sha1md_pkg::ST_EMIT: begin
        if (out_tready) begin
          if (emit_idx_r == sha1md_pkg::IdxLast) begin
            emit_idx_nxt  = '0;
            pad_mode_nxt  = 1'b0;
            len_phase_nxt = 1'b0;
            done_nxt      = 1'b0;
            state_nxt     = sha1md_pkg::ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 3'd1;
          end
        end
      end
      default: state_nxt = sha1md_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.push_sel = sha1md_pkg::PUSH_DATA;
    cmd.emit_idx = emit_idx_r;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    case (state_r)
      sha1md_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          cmd.push        = 1'b1;
          cmd.push_sel    = in_kind ? sha1md_pkg::PUSH_MARK : sha1md_pkg::PUSH_DATA;
          cmd.len_inc     = !in_kind;
          cmd.load_rounds = stat.cnt_is_63;
        end
      end
      sha1md_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
      end
      sha1md_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      sha1md_pkg::ST_PAD: begin
        cmd.push        = 1'b1;
        cmd.push_sel    = len_now ? sha1md_pkg::PUSH_LEN : sha1md_pkg::PUSH_ZERO;
        cmd.load_rounds = stat.cnt_is_63;
      end
      sha1md_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        cmd.reinit = out_tready && (emit_idx_r == sha1md_pkg::IdxLast);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_fold_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold |-> $past(cmd.round_step && stat.round_last))
    else $error("fold without a completed round sequence");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("digest beat offered while taking input");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit_idx_r <= sha1md_pkg::IdxLast)
    else $error("digest word index out of range");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && emit_idx_r == sha1md_pkg::IdxLast)
      |=> (state_r == sha1md_pkg::ST_IDLE && !pad_mode_r))
    else $error("no return to idle after final digest beat");

  a_done_only_padding: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> pad_mode_r)
    else $error("length written outside padding");

endmodule

// File: design/sha1_message_digest_core.sv
// top level of the sha-1 message digest core
//
// input stream: one beat per message byte (in_tuser = 0) or a finish beat
// (in_tuser = 1). a byte beat is taken while in_tready is high; the byte that
// completes a 64-byte block is followed by the compression rounds, run one at a
// time by the single round unit, and a fold into the chaining value.
// in_tready is low while a block is compressed, padded or the digest goes out.
// a finish beat pads one byte per cycle (0x80, zeros, 64-bit bit length),
// running one or two compressions, then offers five digest beats on the
// output stream, most significant word first, out_tlast on the fifth.
// the digest beat is held until out_tready is seen; no input is taken
// meanwhile, and after the fifth beat the core starts a fresh message.
// rst_n (synchronous, active low) loads the initial hash, clears the byte and
// length counts and returns the sequencer to idle.
module sha1_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_word
);

  sha1md_pkg::cmd_t  cmd;
  sha1md_pkg::stat_t stat;
  logic [31:0]       digest_word;

  sha1md_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  sha1md_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_tdata),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign out_tdata = {5'b00000, cmd.emit_idx, digest_word};
  assign out_tlast = (cmd.emit_idx == sha1md_pkg::IdxLast);

endmodule
